### rtl/fcw_pkg.sv
// Shared types, constants and the color wheel table for the flow color wheel.
// No dependencies; every rtl file imports it.
package fcw_pkg;

    localparam int NCOLS       = 55;
    localparam int CORDIC_N    = 20;
    localparam int SQRT_N      = 28;
    localparam int DIV_N       = 28;
    localparam int ZW          = 26;
    localparam int XW          = 36;
    localparam logic [22:0] QUARTER = 23'd4194304;
    localparam logic [14:0] MAX_MOTION_RST = 15'd2560;

    // register index, taken from paddr[2]
    localparam logic REG_MAX_MOTION = 1'b0;

    typedef logic [23:0] wheel_rom_t [NCOLS];

    typedef struct packed {
        logic                 vld;
        logic                 fv;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [31:0]          s;
        logic                 fx_neg;
        logic                 fy_neg;
        logic                 ax_zero;
        logic                 ay_zero;
    } cordic_t;

    typedef struct packed {
        logic        vld;
        logic        fv;
        logic [23:0] h;
        logic [55:0] v;
        logic [56:0] r;
    } sqrt_t;

    typedef struct packed {
        logic        vld;
        logic        fv;
        logic [23:0] h;
        logic [27:0] n;
        logic [14:0] rem;
        logic [27:0] q;
    } div_t;

    function automatic logic [21:0] atan_turns(input logic [4:0] i);
        logic [21:0] a;
        begin
            case (i)
                5'd0:    a = 22'd2097152;
                5'd1:    a = 22'd1238021;
                5'd2:    a = 22'd654136;
                5'd3:    a = 22'd332050;
                5'd4:    a = 22'd166669;
                5'd5:    a = 22'd83416;
                5'd6:    a = 22'd41718;
                5'd7:    a = 22'd20860;
                5'd8:    a = 22'd10430;
                5'd9:    a = 22'd5215;
                5'd10:   a = 22'd2608;
                5'd11:   a = 22'd1304;
                5'd12:   a = 22'd652;
                5'd13:   a = 22'd326;
                5'd14:   a = 22'd163;
                5'd15:   a = 22'd81;
                5'd16:   a = 22'd41;
                5'd17:   a = 22'd20;
                5'd18:   a = 22'd10;
                5'd19:   a = 22'd5;
                default: a = 22'd0;
            endcase
            return a;
        end
    endfunction

    // Evaluated at elaboration only.
    function automatic wheel_rom_t build_wheel();
        wheel_rom_t w;
        int r;
        int g;
        int b;
        int k;
        begin
            for (int i = 0; i < NCOLS; i++) begin
                k = i;
                if (k < 15) begin
                    r = 255; g = 255 * k / 15; b = 0;
                end else if (k < 21) begin
                    k = k - 15; r = 255 - 255 * k / 6; g = 255; b = 0;
                end else if (k < 25) begin
                    k = k - 21; r = 0; g = 255; b = 255 * k / 4;
                end else if (k < 36) begin
                    k = k - 25; r = 0; g = 255 - 255 * k / 11; b = 255;
                end else if (k < 49) begin
                    k = k - 36; r = 255 * k / 13; g = 0; b = 255;
                end else begin
                    k = k - 49; r = 255; g = 0; b = 255 - 255 * k / 6;
                end
                w[i] = {8'(r), 8'(g), 8'(b)};
            end
            return w;
        end
    endfunction

    localparam wheel_rom_t WHEEL_ROM = build_wheel();

endpackage

### rtl/flow_color_wheel_top.sv
// Flow color wheel: maps a Q7.8 flow vector to an RGB color, one vector per clock
// while the output is taken. Pipeline stages: input stage, 20 CORDIC cells, 28 square
// root cells, 28 divider cells, 5 color stages. Throughput one word per cycle; the whole
// chain holds while the output word waits. Reset clears all valid bits and
// loads max_motion with 2560. Depends on fcw_pkg, fcw_color and the cell modules.
module flow_color_wheel_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] flow_x,
    input  logic signed [15:0] flow_y,
    input  logic               flow_valid,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         red,
    output logic [7:0]         green,
    output logic [7:0]         blue
);
    import fcw_pkg::*;

    logic        en;
    logic [14:0] max_motion_reg;
    logic [14:0] m;

    logic        pv_reg, pfv_reg, pxn_reg, pyn_reg;
    logic [31:0] fx2_reg, fy2_reg;
    logic [16:0] ax_reg, ay_reg;
    logic [16:0] ax, ay;

    cordic_t cor [CORDIC_N+1];
    sqrt_t   sq  [SQRT_N+1];
    div_t    dv  [DIV_N+1];

    logic signed [ZW-1:0] zc;
    logic [22:0] phi;
    logic [23:0] h;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_MOTION) ? {17'd0, max_motion_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_motion_reg <= MAX_MOTION_RST;
        else if (psel && penable && pwrite && paddr[2] == REG_MAX_MOTION)
            max_motion_reg <= pwdata[14:0];
    end

    assign m = (max_motion_reg == 15'd0) ? 15'd1 : max_motion_reg;

    // hold everything while the output word is not taken
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    assign ax = flow_x[15] ? 17'd0 - {flow_x[15], flow_x} : {1'b0, flow_x};
    assign ay = flow_y[15] ? 17'd0 - {flow_y[15], flow_y} : {1'b0, flow_y};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= 1'b0;
        else if (en)
            pv_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pfv_reg <= flow_valid;
            pxn_reg <= flow_x[15];
            pyn_reg <= flow_y[15];
            fx2_reg <= 32'(flow_x * flow_x);
            fy2_reg <= 32'(flow_y * flow_y);
            ax_reg  <= ax;
            ay_reg  <= ay;
        end
    end

    always_comb
    begin
        cor[0].vld     = pv_reg;
        cor[0].fv      = pfv_reg;
        cor[0].x       = XW'({ax_reg, 16'd0});
        cor[0].y       = XW'({ay_reg, 16'd0});
        cor[0].z       = '0;
        cor[0].s       = fx2_reg + fy2_reg;
        cor[0].fx_neg  = pxn_reg;
        cor[0].fy_neg  = pyn_reg;
        cor[0].ax_zero = (ax_reg == 17'd0);
        cor[0].ay_zero = (ay_reg == 17'd0);
    end

    for (genvar i = 0; i < CORDIC_N; i++)
    begin : g_cordic
        fcw_cordic_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .idx   (5'(i)),
            .d_in  (cor[i]),
            .d_out (cor[i+1])
        );
    end

    // clamp the angle, then mirror it into the vector's quadrant
    always_comb
    begin
        zc = cor[CORDIC_N].z;
        if (cor[CORDIC_N].ay_zero)
            phi = 23'd0;
        else if (cor[CORDIC_N].ax_zero)
            phi = QUARTER;
        else if (zc < 0)
            phi = 23'd0;
        else if (zc > $signed(ZW'(QUARTER)))
            phi = QUARTER;
        else
            phi = zc[22:0];

        if (!cor[CORDIC_N].fx_neg && !cor[CORDIC_N].fy_neg)
            h = {1'b0, phi};
        else if (cor[CORDIC_N].fx_neg && !cor[CORDIC_N].fy_neg)
            h = 24'h800000 - {1'b0, phi};
        else if (cor[CORDIC_N].fx_neg)
            h = 24'h800000 + {1'b0, phi};
        else
            h = 24'd0 - {1'b0, phi};

        sq[0].vld = cor[CORDIC_N].vld;
        sq[0].fv  = cor[CORDIC_N].fv;
        sq[0].h   = h;
        sq[0].v   = {cor[CORDIC_N].s, 24'd0};
        sq[0].r   = '0;
    end

    for (genvar i = 0; i < SQRT_N; i++)
    begin : g_sqrt
        fcw_sqrt_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .idx   (5'(i)),
            .d_in  (sq[i]),
            .d_out (sq[i+1])
        );
    end

    always_comb
    begin
        dv[0].vld = sq[SQRT_N].vld;
        dv[0].fv  = sq[SQRT_N].fv;
        dv[0].h   = sq[SQRT_N].h;
        dv[0].n   = sq[SQRT_N].r[27:0];
        dv[0].rem = '0;
        dv[0].q   = '0;
    end

    for (genvar i = 0; i < DIV_N; i++)
    begin : g_div
        fcw_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .m     (m),
            .d_in  (dv[i]),
            .d_out (dv[i+1])
        );
    end

    fcw_color u_color (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .d_in    (dv[DIV_N]),
        .out_vld (out_valid),
        .red     (red),
        .green   (green),
        .blue    (blue)
    );
endmodule

### rtl/fcw_cordic_cell.sv
// One vectoring CORDIC iteration with its pipeline register.
// Depends on fcw_pkg.
module fcw_cordic_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic [4:0]      idx,
    input  fcw_pkg::cordic_t d_in,
    output fcw_pkg::cordic_t d_out
);
    import fcw_pkg::*;

    cordic_t d_reg;
    cordic_t d_next;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic [ZW-1:0] a;

    always_comb
    begin
        d_next = d_in;
        dx = d_in.y >>> idx;
        dy = d_in.x >>> idx;
        a  = ZW'(atan_turns(idx));
        if (d_in.y > 0)
        begin
            d_next.x = d_in.x + dx;
            d_next.y = d_in.y - dy;
            d_next.z = d_in.z + $signed(a);
        end
        else
        begin
            d_next.x = d_in.x - dx;
            d_next.y = d_in.y + dy;
            d_next.z = d_in.z - $signed(a);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_reg <= '0;
        else if (en)
            d_reg <= d_next;
    end

    assign d_out = d_reg;
endmodule

### rtl/fcw_sqrt_cell.sv
// One bit of the integer square root with its pipeline register.
// Depends on fcw_pkg.
module fcw_sqrt_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic [4:0]     idx,
    input  fcw_pkg::sqrt_t d_in,
    output fcw_pkg::sqrt_t d_out
);
    import fcw_pkg::*;

    sqrt_t d_reg;
    sqrt_t d_next;
    logic [5:0]  sh;
    logic [56:0] b;
    logic [56:0] t;

    always_comb
    begin
        d_next = d_in;
        sh = 6'd54 - {idx, 1'b0};
        b  = 57'd1 << sh;
        t  = d_in.r + b;
        if ({1'b0, d_in.v} >= t)
        begin
            d_next.v = d_in.v - t[55:0];
            d_next.r = (d_in.r >> 1) + b;
        end
        else
        begin
            d_next.r = d_in.r >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_reg <= '0;
        else if (en)
            d_reg <= d_next;
    end

    assign d_out = d_reg;
endmodule

### rtl/fcw_div_cell.sv
// One quotient bit of the restoring divider with its pipeline register.
// Depends on fcw_pkg.
module fcw_div_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic [14:0]   m,
    input  fcw_pkg::div_t d_in,
    output fcw_pkg::div_t d_out
);
    import fcw_pkg::*;

    div_t d_reg;
    div_t d_next;
    logic [15:0] sh;
    logic        qb;

    always_comb
    begin
        d_next = d_in;
        sh = {d_in.rem, d_in.n[27]};
        qb = (sh >= {1'b0, m});
        d_next.rem = qb ? 15'(sh - {1'b0, m}) : sh[14:0];
        d_next.n   = d_in.n << 1;
        d_next.q   = {d_in.q[26:0], qb};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_reg <= '0;
        else if (en)
            d_reg <= d_next;
    end

    assign d_out = d_reg;
endmodule

### rtl/fcw_color.sv
// Wheel lookup, interpolation and saturation stages; last stage is the output word.
// Depends on fcw_pkg.
module fcw_color (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  fcw_pkg::div_t d_in,
    output logic          out_vld,
    output logic [7:0]    red,
    output logic [7:0]    green,
    output logic [7:0]    blue
);
    import fcw_pkg::*;

    // stage 1
    logic        v1_reg, fv1_reg, in1_reg;
    logic [17:0] fk1_reg;
    logic [12:0] rad1_reg;
    logic [29:0] hp;
    // stage 2
    logic        v2_reg, fv2_reg, in2_reg;
    logic [12:0] rad2_reg;
    logic [19:0] p0_reg [3];
    logic [19:0] p1_reg [3];
    logic [5:0]  k0, k1;
    logic [11:0] f;
    logic [12:0] wf;
    logic [23:0] e0, e1;
    // stage 3
    logic        v3_reg, fv3_reg, in3_reg;
    logic [12:0] rad3_reg;
    logic [19:0] cq3_reg [3];
    // stage 4
    logic        v4_reg, fv4_reg, in4_reg;
    logic [31:0] pr4_reg [3];
    logic [21:0] tr4_reg [3];
    // stage 5
    logic        v5_reg;
    logic [7:0]  ch5_reg [3];
    logic [7:0]  ch5_next [3];

    assign hp = {6'd0, d_in.h} * 30'(NCOLS - 1);

    always_comb
    begin
        k0 = fk1_reg[17:12];
        if (k0 > 6'(NCOLS - 1))
            k0 = 6'(NCOLS - 1);
        k1 = (k0 == 6'(NCOLS - 1)) ? 6'd0 : k0 + 6'd1;
        f  = fk1_reg[11:0];
        wf = 13'd4096 - {1'b0, f};
        e0 = WHEEL_ROM[k0];
        e1 = WHEEL_ROM[k1];
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (!fv4_reg)
                ch5_next[c] = 8'd0;
            else if (in4_reg)
                ch5_next[c] = 8'((32'd4278190080 - pr4_reg[c]) >> 24);
            else
                ch5_next[c] = tr4_reg[c][21:14];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= d_in.vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fv1_reg  <= d_in.fv;
            fk1_reg  <= hp[29:12];
            in1_reg  <= (d_in.q <= 28'd4096);
            rad1_reg <= d_in.q[12:0];

            fv2_reg  <= fv1_reg;
            in2_reg  <= in1_reg;
            rad2_reg <= rad1_reg;
            for (int c = 0; c < 3; c++)
            begin
                p0_reg[c] <= 20'(e0[23-8*c -: 8]) * 20'(wf);
                p1_reg[c] <= 20'(e1[23-8*c -: 8]) * 20'(f);
            end

            fv3_reg  <= fv2_reg;
            in3_reg  <= in2_reg;
            rad3_reg <= rad2_reg;
            for (int c = 0; c < 3; c++)
                cq3_reg[c] <= p0_reg[c] + p1_reg[c];

            fv4_reg <= fv3_reg;
            in4_reg <= in3_reg;
            for (int c = 0; c < 3; c++)
            begin
                pr4_reg[c] <= 32'(rad3_reg) * 32'(20'd1044480 - cq3_reg[c]);
                tr4_reg[c] <= 22'(cq3_reg[c]) * 22'd3;
            end

            for (int c = 0; c < 3; c++)
                ch5_reg[c] <= ch5_next[c];
        end
    end

    assign out_vld = v5_reg;
    assign red     = ch5_reg[0];
    assign green   = ch5_reg[1];
    assign blue    = ch5_reg[2];
endmodule

### bench/tb_flow_color_wheel_top.sv
// Testbench for flow_color_wheel_top: directed table plus random flow vectors, checked
// against an integer color wheel predictor. Depends on fcw_pkg and the rtl files.
`timescale 1ns / 100ps

module tb_flow_color_wheel_top;
    import fcw_pkg::*;

    localparam int LATENCY = 82;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    typedef struct {
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic               fv;
        logic               known;
        rgb_t               color;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [15:0] flow_x = '0;
    logic signed [15:0] flow_y = '0;
    logic               flow_valid = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;

    rgb_t       color_queue[$];
    logic [14:0] motion_scale;
    int         error_count = 0;
    int         words_sent = 0;
    int         words_checked = 0;
    bit         hold_off_long = 1'b0;
    bit         hold_active = 1'b0;
    bit         sink_idle_ok = 1'b1;

    always #6 clk = ~clk;

    flow_color_wheel_top dut (.*);

    initial
    begin
        #50ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int wheel_chan(input int k, input int b);
        int c[3];
        if (k < 15) begin c[0] = 255; c[1] = 255 * k / 15; c[2] = 0; end
        else if (k < 21) begin k -= 15; c[0] = 255 - 255 * k / 6; c[1] = 255; c[2] = 0; end
        else if (k < 25) begin k -= 21; c[0] = 0; c[1] = 255; c[2] = 255 * k / 4; end
        else if (k < 36) begin k -= 25; c[0] = 0; c[1] = 255 - 255 * k / 11; c[2] = 255; end
        else if (k < 49) begin k -= 36; c[0] = 255 * k / 13; c[1] = 0; c[2] = 255; end
        else begin k -= 49; c[0] = 255; c[1] = 0; c[2] = 255 - 255 * k / 6; end
        return c[b];
    endfunction

    function automatic longint hue_quadrant(input longint ax, input longint ay);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint atan_step[20] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
            20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};
        z = 0;
        if (ay == 0) return 0;
        if (ax == 0) return 64'd4194304;
        x = ax * 65536;
        y = ay * 65536;
        for (int i = 0; i < 20; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin x += dx; y -= dy; z += atan_step[i]; end
            else begin x -= dx; y += dy; z -= atan_step[i]; end
        end
        if (z < 0) z = 0;
        if (z > 4194304) z = 4194304;
        return z;
    endfunction

    function automatic rgb_t flow_to_color(input logic signed [15:0] fx16,
                                           input logic signed [15:0] fy16, input logic fv);
        rgb_t   c;
        longint fx;
        longint fy;
        longint m;
        longint rad;
        longint phi;
        longint h;
        longint fk;
        longint f;
        longint cq;
        longint v;
        longint lo;
        longint mid;
        longint tgt;
        int     k0;
        int     k1;
        int     chan[3];
        c = '{8'd0, 8'd0, 8'd0};
        if (!fv) return c;
        fx = fx16;
        fy = fy16;
        m = (motion_scale == 0) ? 1 : motion_scale;
        // floor sqrt of (fx^2+fy^2)<<24 by binary search
        tgt = (fx * fx + fy * fy) << 24;
        lo = 0;
        for (longint hi = 64'd3037000499; lo < hi; ) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= tgt) lo = mid; else hi = mid - 1;
        end
        rad = lo / m;
        phi = hue_quadrant(fx < 0 ? -fx : fx, fy < 0 ? -fy : fy);
        if (fx >= 0 && fy >= 0) h = phi;
        else if (fx < 0 && fy >= 0) h = 2 * 4194304 - phi;
        else if (fx < 0) h = 2 * 4194304 + phi;
        else h = (16777216 - phi) & 16777215;
        fk = (h * 54) >> 12;
        k0 = int'(fk >> 12);
        if (k0 > 54) k0 = 54;
        k1 = (k0 + 1) % 55;
        f = fk & 4095;
        for (int b = 0; b < 3; b++) begin
            cq = wheel_chan(k0, b) * (4096 - f) + wheel_chan(k1, b) * f;
            if (rad <= 4096) v = (longint'(255) * 16777216 - rad * (255 * 4096 - cq)) >>> 24;
            else v = (3 * cq) >>> 14;
            chan[b] = int'(v & 255);
        end
        c.r = 8'(chan[0]);
        c.g = 8'(chan[1]);
        c.b = 8'(chan[2]);
        return c;
    endfunction

    task automatic write_motion(input logic [14:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {REG_MAX_MOTION, 2'b00}; pwdata <= {17'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        motion_scale = value;
    endtask

    task automatic send_word(input logic signed [15:0] fx, input logic signed [15:0] fy,
                             input logic fv);
        in_valid <= 1'b1; flow_x <= fx; flow_y <= fy; flow_valid <= fv;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        color_queue = {color_queue, flow_to_color(fx, fy, fv)};
        words_sent++;
    endtask

    task automatic source_gap();
        int n;
        n = ($urandom_range(0, 9) < 6) ? 0 :
            (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3));
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        while (color_queue.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // long receiver hold-off, timed in cycles once requested
    initial
    begin
        wait (hold_off_long);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (400) @(posedge clk);
        hold_active <= 1'b0;
    end

    // sink: random stalls, plus one long hold-off on request; always ready for the final drain
    always @(posedge clk)
    begin
        if (!rst_n) out_ready <= 1'b0;
        else if (!sink_idle_ok) out_ready <= 1'b1;
        else if (hold_active) out_ready <= 1'b0;
        else out_ready <= ($urandom_range(0, 9) < 7);
    end

    always @(posedge clk)
    begin
        rgb_t exp_c;
        if (rst_n && out_valid && out_ready)
        begin
            if (color_queue.size() == 0)
            begin
                $error("output word with nothing expected: %0d %0d %0d", red, green, blue);
                error_count++;
            end
            else
            begin
                exp_c = color_queue.pop_front();
                if (red !== exp_c.r)
                begin
                    $error("red expected %0d actual %0d", exp_c.r, red); error_count++;
                end
                if (green !== exp_c.g)
                begin
                    $error("green expected %0d actual %0d", exp_c.g, green); error_count++;
                end
                if (blue !== exp_c.b)
                begin
                    $error("blue expected %0d actual %0d", exp_c.b, blue); error_count++;
                end
                words_checked++;
            end
        end
    end

    initial
    begin
        stim_row_t rows[$];
        rgb_t      got;
        logic [14:0] scales[6] = '{15'd2560, 15'd1, 15'd32767, 15'd256, 15'd0, 15'd700};
        int        sel;
        motion_scale = MAX_MOTION_RST;
        rows = '{
            '{16'sd0, 16'sd0, 1'b0, 1'b1, '{8'd0, 8'd0, 8'd0}},
            '{16'sd0, 16'sd0, 1'b1, 1'b1, '{8'd255, 8'd255, 8'd255}},
            '{16'sd32767, -16'sd32768, 1'b0, 1'b1, '{8'd0, 8'd0, 8'd0}},
            '{16'sd32767, 16'sd0, 1'b1, 1'b0, '{8'd0, 8'd0, 8'd0}},
            '{-16'sd32768, 16'sd0, 1'b1, 1'b0, '{8'd0, 8'd0, 8'd0}},
            '{16'sd0, 16'sd32767, 1'b1, 1'b0, '{8'd0, 8'd0, 8'd0}},
            '{16'sd0, -16'sd32768, 1'b1, 1'b0, '{8'd0, 8'd0, 8'd0}},
            '{-16'sd32768, -16'sd32768, 1'b1, 1'b0, '{8'd0, 8'd0, 8'd0}},
            '{16'sd32767, 16'sd32767, 1'b1, 1'b0, '{8'd0, 8'd0, 8'd0}},
            '{16'sd2560, 16'sd0, 1'b1, 1'b0, '{8'd0, 8'd0, 8'd0}},
            '{16'sd1000, -16'sd1000, 1'b1, 1'b0, '{8'd0, 8'd0, 8'd0}},
            '{-16'sd1, 16'sd1, 1'b1, 1'b0, '{8'd0, 8'd0, 8'd0}},
            '{-16'sd300, -16'sd2, 1'b1, 1'b0, '{8'd0, 8'd0, 8'd0}},
            '{16'sd5, -16'sd1, 1'b1, 1'b0, '{8'd0, 8'd0, 8'd0}}
        };
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            send_word(rows[i].fx, rows[i].fy, rows[i].fv);
            if (rows[i].known)
            begin
                got = color_queue[$];
                if (got != rows[i].color)
                begin
                    $error("row %0d predictor gives %0d %0d %0d", i, got.r, got.g, got.b);
                    error_count++;
                end
            end
            source_gap();
        end
        in_valid <= 1'b0;
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            repeat (LATENCY + 4) @(posedge clk);
            write_motion(scales[phase]);
            if (phase == 2) hold_off_long = 1'b1;
            for (int n = 0; n < 200; n++)
            begin
                sel = $urandom_range(0, 9);
                if (sel < 5)
                    send_word($signed(16'($urandom_range(0, 4095) - 2048)),
                              $signed(16'($urandom_range(0, 4095) - 2048)), 1'b1);
                else if (sel < 9)
                    send_word($signed(16'($urandom)), $signed(16'($urandom)),
                              $urandom_range(0, 7) != 0);
                else
                    send_word($signed(16'($urandom_range(0, 20) - 10)),
                              $signed(16'($urandom_range(0, 20) - 10)), 1'b1);
                source_gap();
            end
            in_valid <= 1'b0;
            // sender pauses until all colors are back
            drain();
        end

        sink_idle_ok = 1'b0;
        drain();
        repeat (LATENCY) @(posedge clk);
        $display("sent %0d flow words over 6 motion scales, %0d colors checked",
                 words_sent, words_checked);
        if (error_count == 0 && color_queue.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### flow_color_wheel_top.f
rtl/fcw_pkg.sv
rtl/fcw_cordic_cell.sv
rtl/fcw_sqrt_cell.sv
rtl/fcw_div_cell.sv
rtl/fcw_color.sv
rtl/flow_color_wheel_top.sv
bench/tb_flow_color_wheel_top.sv
